[design/mldsa_hint_decoder_core_defines.svh]
// ----------------------------------------------------------------------------
// Hint decoder assertion macros
// Shared assertion forms for the hint section decoder.
// ----------------------------------------------------------------------------
`ifndef MLDSA_HINT_DECODER_CORE_DEFINES_SVH
`define MLDSA_HINT_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHD_ASSERT_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mldsa_hd_pkg.sv]
// ----------------------------------------------------------------------------
// Hint decoder package
// Sizes, codes and state encoding for the hint section decoder.
// ----------------------------------------------------------------------------
package mldsa_hd_pkg;

	// Geometry of one polynomial and of the index store.
	localparam int COEFFS         = 256;
	localparam int MAX_OMEGA      = 128;
	localparam int MAX_POLYS      = 8;
	localparam int WORD_BITS      = 64;
	localparam int WORDS_PER_POLY = COEFFS / WORD_BITS;
	localparam int ADDR_W         = $clog2(MAX_OMEGA);
	localparam int COEF_W         = $clog2(COEFFS);
	localparam int WSEL_W         = $clog2(WORDS_PER_POLY);
	localparam int BSEL_W         = $clog2(WORD_BITS);
	localparam int POLY_W         = 3;

	// Configuration register widths and reset values.
	localparam int OMEGA_W = 8;
	localparam int POLYS_W = 4;
	localparam logic [OMEGA_W-1:0] MAX_HINTS_RST  = 8'd80;
	localparam logic [POLYS_W-1:0] POLY_COUNT_RST = 4'd4;

	// Register indexes on the configuration port.
	localparam logic REG_MAX_HINTS  = 1'b0;
	localparam logic REG_POLY_COUNT = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_WORD      = 2'd0,
		STATUS_VALID     = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT,
		ST_SCAN,
		ST_VERDICT,
		ST_FAIL
	} state_t;

endpackage

[design/mldsa_hint_decoder_core.sv]
// ----------------------------------------------------------------------------
// ML-DSA hint section decoder
// Unpacks the hint section of a signature into per-polynomial hint bitmaps.
// ----------------------------------------------------------------------------
// The block takes one hint byte per input transfer. An index byte is written
// straight into the index store. A count byte walks its new indices through
// the single read port of the index store, one index per cycle, to check
// them, and then emits four bitmap words; the final count byte adds a scan of
// the unused indices and a verdict. The block takes no new byte until the
// current byte is finished; the last result may still wait in the output
// register while the next byte is taken. There is no clearing pass after reset.
`include "mldsa_hint_decoder_core_defines.svh"

module mldsa_hint_decoder_core
	import mldsa_hd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            hint_byte,
	// Output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POLY_W-1:0]     poly_index,
	output logic [WSEL_W-1:0]     word_index,
	output logic [WORD_BITS-1:0]  hint_word,
	output logic [1:0]            status,
	output logic                  last
);

	// Configuration registers and effective values.
	logic [OMEGA_W-1:0] max_hints_q;
	logic [POLYS_W-1:0] poly_count_q;
	logic [OMEGA_W-1:0] omega_eff;
	logic [POLYS_W-1:0] polys_eff;
	logic               cfg_wr;

	// Section and sequencer state.
	state_t             state_q, state_d;
	logic [OMEGA_W-1:0] pos_q;
	logic [OMEGA_W-1:0] prev_q;
	logic               failed_q;
	logic               end_q;
	logic               last_poly_q;
	logic [POLY_W-1:0]  poly_q;
	logic [OMEGA_W-1:0] cnt_q;
	logic [OMEGA_W-1:0] iss_q;
	logic [OMEGA_W-1:0] lim_q;
	logic [OMEGA_W-1:0] start_q;
	logic [COEF_W-1:0]  last_idx_q;
	logic               extra_q;
	logic [WSEL_W-1:0]  word_q;

	// Index store read pipeline.
	logic [7:0]         idx_mem [MAX_OMEGA];
	logic               rd_vld_s1;
	logic               rd_first_s1;
	logic [7:0]         rd_data_s1;

	// Bitmap of the current polynomial.
	logic [WORDS_PER_POLY-1:0][WORD_BITS-1:0] bitmap_q;

	// Output register.
	logic                 out_valid_q;
	logic [POLY_W-1:0]    poly_index_q;
	logic [WSEL_W-1:0]    word_index_q;
	logic [WORD_BITS-1:0] hint_word_q;
	status_t              status_q;
	logic                 last_q;

	// Decoded control.
	logic               in_xfer;
	logic               is_index;
	logic               count_path;
	logic               bad_range;
	logic               sect_end;
	logic               poly_last;
	logic [OMEGA_W-1:0] poly_off;
	logic               issue_more;
	logic               issue;
	logic               walk_bad;
	logic               walk_done;
	logic               out_free;
	logic               load_word;
	logic               load_verdict;
	logic               load_fail;
	logic               enter_emit;
	logic               enter_scan;

	// Clamp the registers to their usable ranges.
	always_comb begin
		if (max_hints_q == '0) begin
			omega_eff = OMEGA_W'(1);
		end else if (max_hints_q > OMEGA_W'(MAX_OMEGA)) begin
			omega_eff = OMEGA_W'(MAX_OMEGA);
		end else begin
			omega_eff = max_hints_q;
		end
		if (poly_count_q == '0) begin
			polys_eff = POLYS_W'(1);
		end else if (poly_count_q > POLYS_W'(MAX_POLYS)) begin
			polys_eff = POLYS_W'(MAX_POLYS);
		end else begin
			polys_eff = poly_count_q;
		end
	end

	// Configuration port: always ready, word-aligned decode.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MAX_HINTS:  prdata = {{(32-OMEGA_W){1'b0}}, max_hints_q};
			REG_POLY_COUNT: prdata = {{(32-POLYS_W){1'b0}}, poly_count_q};
			default:        prdata = '0;
		endcase
	end

	// Classification of the byte on the input channel.
	assign in_xfer    = in_valid && in_ready;
	assign is_index   = pos_q < omega_eff;
	assign count_path = !is_index && !failed_q;
	assign bad_range  = (hint_byte < prev_q) || (hint_byte > omega_eff);
	assign poly_off   = pos_q - omega_eff;
	assign sect_end   = ({1'b0, pos_q} + 9'd1) >= ({1'b0, omega_eff} + 9'(polys_eff));
	assign poly_last  = ({1'b0, poly_off} + 9'd1) >= 9'(polys_eff);

	// Shared walk over the index store: issue one read, check the previous one.
	assign issue_more = iss_q < lim_q;
	assign walk_bad   = (state_q == ST_WALK) && rd_vld_s1 && !rd_first_s1 &&
	                    (rd_data_s1 <= last_idx_q);
	assign walk_done  = !issue_more && !rd_vld_s1;
	assign out_free   = !out_valid_q || out_ready;

	// Sequencer next state and strobes.
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		issue        = 1'b0;
		load_word    = 1'b0;
		load_verdict = 1'b0;
		load_fail    = 1'b0;
		enter_emit   = 1'b0;
		enter_scan   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && count_path) begin
					state_d = bad_range ? ST_FAIL : ST_WALK;
				end
			end
			ST_WALK: begin
				issue = issue_more && !walk_bad;
				if (walk_bad) begin
					state_d = ST_FAIL;
				end else if (walk_done) begin
					state_d    = ST_EMIT;
					enter_emit = 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_word = 1'b1;
					if (word_q == WSEL_W'(WORDS_PER_POLY - 1)) begin
						if (last_poly_q) begin
							state_d    = ST_SCAN;
							enter_scan = 1'b1;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_SCAN: begin
				issue = issue_more;
				if (walk_done) begin
					state_d = ST_VERDICT;
				end
			end
			ST_VERDICT: begin
				if (out_free) begin
					load_verdict = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (out_free) begin
					load_fail = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Section control: position, previous count, failure flag, configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hints_q  <= MAX_HINTS_RST;
			poly_count_q <= POLY_COUNT_RST;
			pos_q        <= '0;
			prev_q       <= '0;
			failed_q     <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_HINTS) begin
				max_hints_q <= pwdata[OMEGA_W-1:0];
			end else begin
				poly_count_q <= pwdata[POLYS_W-1:0];
			end
			pos_q    <= '0;
			prev_q   <= '0;
			failed_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (sect_end) begin
					pos_q    <= '0;
					prev_q   <= '0;
					failed_q <= 1'b0;
				end else begin
					pos_q <= pos_q + OMEGA_W'(1);
				end
			end
			// Outcomes of the byte at work count only inside its section.
			if (!end_q) begin
				if (enter_emit) begin
					prev_q <= cnt_q;
				end
				if (load_fail || (load_verdict && extra_q)) begin
					failed_q <= 1'b1;
				end
			end
		end
	end

	// Per-byte context captured when a count byte is taken.
	always_ff @(posedge clk) begin
		if (in_xfer && count_path) begin
			cnt_q       <= hint_byte;
			poly_q      <= poly_off[POLY_W-1:0];
			last_poly_q <= poly_last;
			end_q       <= sect_end;
		end
	end

	// Index store: written by index bytes, read by the walk.
	always_ff @(posedge clk) begin
		if (in_xfer && is_index) begin
			idx_mem[pos_q[ADDR_W-1:0]] <= hint_byte;
		end
		rd_data_s1 <= idx_mem[iss_q[ADDR_W-1:0]];
	end

	// Read pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	// The walk start is held apart from the previous count, which a section end clears.
	always_ff @(posedge clk) begin
		if (in_xfer && count_path) begin
			iss_q   <= prev_q;
			lim_q   <= hint_byte;
			start_q <= prev_q;
		end else if (enter_scan) begin
			iss_q <= cnt_q;
			lim_q <= omega_eff;
		end else if (issue) begin
			iss_q <= iss_q + OMEGA_W'(1);
		end
		rd_first_s1 <= (iss_q == start_q);
	end

	// Bitmap build and unused-index check.
	always_ff @(posedge clk) begin
		if (in_xfer && count_path) begin
			bitmap_q <= '0;
			word_q   <= '0;
		end else if ((state_q == ST_WALK) && rd_vld_s1 && !walk_bad) begin
			bitmap_q[rd_data_s1[COEF_W-1 -: WSEL_W]][rd_data_s1[BSEL_W-1:0]] <= 1'b1;
			last_idx_q <= rd_data_s1;
		end
		if (load_word) begin
			word_q <= word_q + WSEL_W'(1);
		end
		if (enter_scan) begin
			extra_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && rd_vld_s1 && (rd_data_s1 != '0)) begin
			extra_q <= 1'b1;
		end
	end

	// Output register: one result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_word || load_verdict || load_fail) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			poly_index_q <= poly_q;
			word_index_q <= word_q;
			hint_word_q  <= bitmap_q[word_q];
			status_q     <= STATUS_WORD;
			last_q       <= 1'b0;
		end else if (load_verdict || load_fail) begin
			poly_index_q <= poly_q;
			word_index_q <= '0;
			hint_word_q  <= '0;
			status_q     <= (load_fail || extra_q) ? STATUS_MALFORMED : STATUS_VALID;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign poly_index = poly_index_q;
	assign word_index = word_index_q;
	assign hint_word  = hint_word_q;
	assign status     = status_q;
	assign last       = last_q;

	// Checks on the sequencer and the index store.
	`MHD_ASSERT_SAME(a_last_is_verdict, clk, arst_n, out_valid_q && last_q,
		status_q != STATUS_WORD, "Last result carries a bitmap status")
	`MHD_ASSERT_SAME(a_walk_bound, clk, arst_n,
		(state_q == ST_WALK) || (state_q == ST_SCAN), iss_q <= lim_q,
		"Walk address passed its limit")
	`MHD_ASSERT_SAME(a_store_write_idle, clk, arst_n, in_xfer && is_index,
		(state_q == ST_IDLE) && !rd_vld_s1, "Index store written during a walk")
	`MHD_ASSERT_NEXT(a_emit_exit, clk, arst_n,
		load_word && (word_q == WSEL_W'(WORDS_PER_POLY - 1)),
		(state_q == ST_SCAN) || (state_q == ST_IDLE),
		"Bitmap emission did not end after its last word")

endmodule

[bench/mldsa_hint_bitmap_check.sv]
// ----------------------------------------------------------------------------
// Hint bitmap checker
// Watches the configuration port and both data channels of the hint section
// decoder, predicts the bitmap words and verdicts and compares every result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module mldsa_hint_bitmap_check
	import mldsa_hd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           hint_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [POLY_W-1:0]    poly_index,
	input  logic [WSEL_W-1:0]    word_index,
	input  logic [WORD_BITS-1:0] hint_word,
	input  logic [1:0]           status,
	input  logic                 last,
	output int                   mismatch_count,
	output int                   results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [POLY_W-1:0]    poly;
		logic [WSEL_W-1:0]    word;
		logic [WORD_BITS-1:0] bits;
		status_t              code;
		logic                 fin;
	} hint_result_t;

	hint_result_t         expected_results_q[$];
	logic [OMEGA_W-1:0]   hints_reg;
	logic [POLYS_W-1:0]   polys_reg;
	logic [7:0]           index_mem [MAX_OMEGA];
	int                   byte_pos;
	int                   prev_count;
	bit                   section_failed;
	int                   errors;

	assign mismatch_count = errors;

	function automatic int clamp_range(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic queue_result(input int poly, input int word, input logic [WORD_BITS-1:0] bits,
			input status_t code, input logic fin);
		hint_result_t r;
		r.poly = POLY_W'(poly);
		r.word = WSEL_W'(word);
		r.bits = bits;
		r.code = code;
		r.fin  = fin;
		expected_results_q.push_back(r);
	endtask

	// One section byte: store an index, or check a count and build its bitmap.
	task automatic decode_hint_byte(input logic [7:0] b);
		int omega;
		int polys;
		int poly;
		int bv;
		int j;
		bit bad;
		bit extra;
		logic [COEFFS-1:0] bitmap;
		logic [7:0] idx;
		omega = clamp_range(int'(hints_reg), 1, MAX_OMEGA);
		polys = clamp_range(int'(polys_reg), 1, MAX_POLYS);
		bv = int'(b);
		if (byte_pos < omega) begin
			index_mem[byte_pos] = b;
		end else if (!section_failed) begin
			poly = byte_pos - omega;
			bad = (bv < prev_count) || (bv > omega);
			bitmap = '0;
			for (j = prev_count; !bad && j < bv; j++) begin
				idx = index_mem[j];
				if (j > prev_count && idx <= index_mem[j-1]) begin
					bad = 1'b1;
				end else begin
					bitmap[idx] = 1'b1;
				end
			end
			if (bad) begin
				section_failed = 1'b1;
				queue_result(poly, 0, '0, STATUS_MALFORMED, 1'b1);
			end else begin
				prev_count = bv;
				for (j = 0; j < WORDS_PER_POLY; j++) begin
					queue_result(poly, j, bitmap[j*WORD_BITS +: WORD_BITS], STATUS_WORD, 1'b0);
				end
				// The last polynomial closes the section; unused indices must be zero.
				if (poly + 1 >= polys) begin
					extra = 1'b0;
					for (j = bv; j < omega; j++) begin
						if (index_mem[j] != 8'd0) extra = 1'b1;
					end
					if (extra) section_failed = 1'b1;
					queue_result(poly, 0, '0, extra ? STATUS_MALFORMED : STATUS_VALID, 1'b1);
				end
			end
		end
		if (byte_pos + 1 >= omega + polys) begin
			byte_pos = 0;
			prev_count = 0;
			section_failed = 1'b0;
		end else begin
			byte_pos++;
		end
	endtask

	// Compare one result transfer with the oldest prediction, field by field.
	task automatic check_result();
		hint_result_t r;
		if (expected_results_q.size() == 0) begin
			$error("unexpected result: poly_index %0d word_index %0d status %0d last %0d",
				poly_index, word_index, status, last);
			errors++;
		end else begin
			r = expected_results_q.pop_front();
			if (poly_index !== r.poly) begin
				$error("poly_index: expected %0d, actual %0d", r.poly, poly_index);
				errors++;
			end
			if (word_index !== r.word) begin
				$error("word_index: expected %0d, actual %0d", r.word, word_index);
				errors++;
			end
			if (hint_word !== r.bits) begin
				$error("hint_word: expected %h, actual %h", r.bits, hint_word);
				errors++;
			end
			if (status !== r.code) begin
				$error("status: expected %0d, actual %0d", r.code, status);
				errors++;
			end
			if (last !== r.fin) begin
				$error("last: expected %0d, actual %0d", r.fin, last);
				errors++;
			end
		end
	endtask

	// Sample every channel at the rising edge; a register write restarts the section.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hints_reg = MAX_HINTS_RST;
			polys_reg = POLY_COUNT_RST;
			byte_pos = 0;
			prev_count = 0;
			section_failed = 1'b0;
			errors = 0;
			expected_results_q.delete();
			results_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MAX_HINTS) begin
					hints_reg = pwdata[OMEGA_W-1:0];
				end else begin
					polys_reg = pwdata[POLYS_W-1:0];
				end
				byte_pos = 0;
				prev_count = 0;
				section_failed = 1'b0;
			end
			if (out_valid && out_ready) check_result();
			if (in_valid && in_ready) decode_hint_byte(hint_byte);
			results_pending <= expected_results_q.size();
		end
	end

endmodule

[bench/mldsa_hint_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// Hint section decoder testbench
// Drives directed and random hint sections through the decoder under several
// register settings and idle profiles; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module mldsa_hint_decoder_core_test;
	import mldsa_hd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES  = 320;
	localparam int SETTLE_CYCLES = 320;
	localparam int CYCLE_LIMIT   = 600000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           hint_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [POLY_W-1:0]    poly_index;
	logic [WSEL_W-1:0]    word_index;
	logic [WORD_BITS-1:0] hint_word;
	logic [1:0]           status;
	logic                 last;

	int         mismatch_count;
	int         results_pending;
	int         cycle_count = 0;
	int         bytes_sent = 0;
	int         send_gap_pct = 14;
	int         recv_stall_pct = 46;
	logic [7:0] section_q[$];

	always #6 clk = ~clk;

	mldsa_hint_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hint_byte  (hint_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.poly_index (poly_index),
		.word_index (word_index),
		.hint_word  (hint_word),
		.status     (status),
		.last       (last)
	);

	mldsa_hint_bitmap_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.hint_byte       (hint_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.poly_index      (poly_index),
		.word_index      (word_index),
		.hint_word       (hint_word),
		.status          (status),
		.last            (last),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Receiver stalls at random according to the current idle profile.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[mldsa_hint_decoder_core] ERROR");
			$finish;
		end
	end

	// One byte transfer, with an optional gap before it.
	task automatic send_hint_byte(input logic [7:0] b);
		if (bytes_sent < 115) begin
			send_gap_pct = 14;
			recv_stall_pct = 46;
		end else if (bytes_sent < 230) begin
			send_gap_pct = 46;
			recv_stall_pct = 14;
		end else begin
			send_gap_pct = 0;
			recv_stall_pct = 0;
		end
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		hint_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Hold off until every predicted result has come, then let the block settle.
	task automatic wait_drained();
		do @(posedge clk); while (results_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Build one section: mostly well formed with random indices, sometimes damaged.
	task automatic make_section(input int omega, input int polys);
		int counts[MAX_POLYS];
		int total;
		int need;
		int lo;
		int i;
		int j;
		int v;
		int tmp;
		section_q = {};
		total = ($urandom_range(0, 3) == 0) ? $urandom_range(0, omega)
			: $urandom_range(omega / 2, omega);
		for (i = 0; i < polys; i++) counts[i] = $urandom_range(0, total);
		counts[polys-1] = total;
		for (i = 0; i < polys; i++) begin
			for (j = 0; j + 1 < polys - i; j++) begin
				if (counts[j] > counts[j+1]) begin
					tmp = counts[j];
					counts[j] = counts[j+1];
					counts[j+1] = tmp;
				end
			end
		end
		// Pick each polynomial's new indices in increasing order.
		for (i = 0; i < polys; i++) begin
			lo = (i == 0) ? 0 : counts[i-1];
			need = counts[i] - lo;
			for (v = 0; v < COEFFS && need > 0; v++) begin
				if ($urandom_range(0, COEFFS - 1 - v) < need) begin
					section_q.push_back(v[7:0]);
					need--;
				end
			end
		end
		while (section_q.size() < omega) section_q.push_back(8'd0);
		for (i = 0; i < polys; i++) section_q.push_back(counts[i][7:0]);
		case ($urandom_range(0, 9))
			0: begin
				section_q[$urandom_range(0, omega + polys - 1)] = 8'($urandom_range(0, 255));
			end
			1: begin
				if (total < omega) section_q[$urandom_range(total, omega - 1)] =
					8'($urandom_range(1, 255));
			end
			2: begin
				section_q[omega + $urandom_range(0, polys - 1)] =
					8'($urandom_range(omega + 1, 255));
			end
			3: begin
				foreach (section_q[i]) section_q[i] = 8'($urandom_range(0, 255));
			end
			default: begin
			end
		endcase
	endtask

	initial begin
		logic [7:0] directed_bytes [24];
		int seg;
		int seg_items;
		int mh;
		int pc;
		int omega;
		int polys;

		directed_bytes = '{
			8'd5, 8'd200, 8'd1,   8'd2,
			8'd0, 8'd255, 8'd2,   8'd2,
			8'd1, 8'd2,   8'd255, 8'd0,
			8'd1, 8'd2,   8'd2,   8'd1,
			8'd9, 8'd9,   8'd2,   8'd2,
			8'd7, 8'd5,   8'd1,   8'd1
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sections with two indices and two counts: a plain valid
		// section, extreme index values, a count above the limit, a falling
		// count, repeated indices and a nonzero unused index.
		write_reg(REG_MAX_HINTS, 32'd2);
		write_reg(REG_POLY_COUNT, 32'd2);
		foreach (directed_bytes[i]) send_hint_byte(directed_bytes[i]);
		in_valid <= 1'b0;

		// Random sections, each group under a fresh register setting.
		seg = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			wait_drained();
			case (seg)
				0: begin
					mh = 0;
					pc = 0;
				end
				2: begin
					mh = 255;
					pc = 15;
				end
				4: begin
					mh = 1;
					pc = 8;
				end
				default: begin
					mh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
						: $urandom_range(1, 12);
					pc = $urandom_range(0, 15);
				end
			endcase
			write_reg(REG_MAX_HINTS, ($urandom() & 32'hFFFF_FF00) | mh);
			write_reg(REG_POLY_COUNT, ($urandom() & 32'hFFFF_FFF0) | pc);
			omega = (mh < 1) ? 1 : ((mh > MAX_OMEGA) ? MAX_OMEGA : mh);
			polys = (pc < 1) ? 1 : ((pc > MAX_POLYS) ? MAX_POLYS : pc);
			seg_items = 0;
			do begin
				make_section(omega, polys);
				foreach (section_q[i]) send_hint_byte(section_q[i]);
				seg_items += section_q.size();
			end while (seg_items < 30 && omega < 64);
			in_valid <= 1'b0;
			seg++;
		end

		wait_drained();
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("[mldsa_hint_decoder_core] OK");
		end else begin
			$display("[mldsa_hint_decoder_core] ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/mldsa_hd_pkg.sv
design/mldsa_hint_decoder_core.sv
bench/mldsa_hint_bitmap_check.sv
bench/mldsa_hint_decoder_core_test.sv
